### rtl/jlfng_pkg.sv
// Shared types and constants for the line framer with nesting guard.
// Depends on nothing; imported by every module of the block.
package jlfng_pkg;

  localparam int LINE_CAPACITY = 4096;
  localparam int BYTE_W  = 8;
  localparam int LEN_W   = 12;
  localparam int DEPTH_W = 5;
  localparam int MAXD_W  = 4;
  localparam int VERD_W  = 3;

  localparam logic [LEN_W-1:0]  CNT_LIMIT  = LEN_W'(LINE_CAPACITY - 1);
  localparam logic [MAXD_W-1:0] MAXD_RESET = MAXD_W'(8);

  localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;
  localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
  localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_LBRACE = 8'h7B;
  localparam logic [BYTE_W-1:0] CH_RBRACE = 8'h7D;
  localparam logic [BYTE_W-1:0] CH_LBRACK = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_RBRACK = 8'h5D;

  localparam logic [VERD_W-1:0] V_OK         = 3'd0;
  localparam logic [VERD_W-1:0] V_EMPTY      = 3'd1;
  localparam logic [VERD_W-1:0] V_OVERFLOW   = 3'd2;
  localparam logic [VERD_W-1:0] V_TOO_DEEP   = 3'd3;
  localparam logic [VERD_W-1:0] V_UNDERFLOW  = 3'd4;
  localparam logic [VERD_W-1:0] V_OPEN_STR   = 3'd5;
  localparam logic [VERD_W-1:0] V_UNBALANCED = 3'd6;

  localparam logic [1:0] F_NONE     = 2'd0;
  localparam logic [1:0] F_TOO_DEEP = 2'd1;
  localparam logic [1:0] F_UNDER    = 2'd2;

  typedef struct packed {
    logic              eol;
    logic [VERD_W-1:0] verdict;
    logic [LEN_W-1:0]  length;
  } line_res_t;

endpackage

### rtl/jlfng_in_reg.sv
// Input register for received bytes.
// Depends on jlfng_pkg.
module jlfng_in_reg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [jlfng_pkg::BYTE_W-1:0] in_byte,
  input  logic                        consume,
  output logic                        held_valid,
  output logic [jlfng_pkg::BYTE_W-1:0] held_byte
);
  import jlfng_pkg::*;

  assign in_ready = !held_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_byte <= in_byte;
    end
  end

endmodule

### rtl/jlfng_scan.sv
// Line state and per-byte scan: count, overflow, quoting, nesting, verdict.
// Depends on jlfng_pkg.
module jlfng_scan (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [jlfng_pkg::MAXD_W-1:0] max_depth,
  input  logic [jlfng_pkg::BYTE_W-1:0] rx,
  input  logic                         consume,
  output jlfng_pkg::line_res_t         res
);
  import jlfng_pkg::*;

  logic [LEN_W-1:0]   byte_count, byte_count_next;
  logic               overflow_flag, overflow_flag_next;
  logic               in_string, in_string_next;
  logic               after_escape, after_escape_next;
  logic [DEPTH_W-1:0] nesting_depth, nesting_depth_next;
  logic [1:0]         nest_fault, nest_fault_next;
  logic [DEPTH_W-1:0] depth_inc;
  logic               is_open, is_close;

  assign depth_inc = nesting_depth + DEPTH_W'(1);
  assign is_open   = (rx == CH_LBRACE) || (rx == CH_LBRACK);
  assign is_close  = (rx == CH_RBRACE) || (rx == CH_RBRACK);

  always_comb begin
    res.eol    = (rx == CH_LF);
    res.length = byte_count;
    if (overflow_flag) begin
      res.verdict = V_OVERFLOW;
    end else if (byte_count == '0) begin
      res.verdict = V_EMPTY;
    end else if (nest_fault == F_TOO_DEEP) begin
      res.verdict = V_TOO_DEEP;
    end else if (nest_fault == F_UNDER) begin
      res.verdict = V_UNDERFLOW;
    end else if (in_string) begin
      res.verdict = V_OPEN_STR;
    end else if (nesting_depth != '0) begin
      res.verdict = V_UNBALANCED;
    end else begin
      res.verdict = V_OK;
    end
  end

  always_comb begin
    byte_count_next    = byte_count;
    overflow_flag_next = overflow_flag;
    in_string_next     = in_string;
    after_escape_next  = after_escape;
    nesting_depth_next = nesting_depth;
    nest_fault_next    = nest_fault;
    if (rx == CH_LF) begin
      byte_count_next    = '0;
      overflow_flag_next = 1'b0;
      in_string_next     = 1'b0;
      after_escape_next  = 1'b0;
      nesting_depth_next = '0;
      nest_fault_next    = F_NONE;
    end else if (rx == CH_NUL) begin
      overflow_flag_next = 1'b1;
    end else if (rx != CH_CR) begin
      if (!overflow_flag && (byte_count < CNT_LIMIT)) begin
        byte_count_next = byte_count + LEN_W'(1);
        if (nest_fault == F_NONE) begin
          if (in_string) begin
            if (after_escape) begin
              after_escape_next = 1'b0;
            end else if (rx == CH_BSLASH) begin
              after_escape_next = 1'b1;
            end else if (rx == CH_QUOTE) begin
              in_string_next = 1'b0;
            end
          end else if (rx == CH_QUOTE) begin
            in_string_next = 1'b1;
          end else if (is_open) begin
            nesting_depth_next = depth_inc;
            if (depth_inc > DEPTH_W'(max_depth)) begin
              nest_fault_next = F_TOO_DEEP;
            end
          end else if (is_close) begin
            if (nesting_depth == '0) begin
              nest_fault_next = F_UNDER;
            end else begin
              nesting_depth_next = nesting_depth - DEPTH_W'(1);
            end
          end
        end
      end else begin
        overflow_flag_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count    <= '0;
      overflow_flag <= 1'b0;
      in_string     <= 1'b0;
      after_escape  <= 1'b0;
      nesting_depth <= '0;
      nest_fault    <= F_NONE;
    end else if (consume) begin
      byte_count    <= byte_count_next;
      overflow_flag <= overflow_flag_next;
      in_string     <= in_string_next;
      after_escape  <= after_escape_next;
      nesting_depth <= nesting_depth_next;
      nest_fault    <= nest_fault_next;
    end
  end

  a_escape_in_string: assert property (@(posedge clk) disable iff (rst)
    after_escape |-> in_string)
    else $error("escape flag set outside a string");

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    nesting_depth <= DEPTH_W'(16))
    else $error("nesting depth beyond guard range");

  a_fault_freezes: assert property (@(posedge clk) disable iff (rst)
    (nest_fault != F_NONE) && !(consume && (rx == CH_LF))
    |=> $stable(nesting_depth) && $stable(in_string))
    else $error("scan advanced after a nest fault");

  a_eol_clears: assert property (@(posedge clk) disable iff (rst)
    consume && (rx == CH_LF)
    |=> (byte_count == '0) && !overflow_flag && (nest_fault == F_NONE))
    else $error("line state not cleared at newline");

endmodule

### rtl/json_line_framer_nesting_guard_core.sv
// Top level of the line framer with nesting guard: config register,
// result register and glue. Depends on jlfng_pkg, jlfng_in_reg, jlfng_scan.
//
// Usage:
//   Bytes enter on in_valid/in_ready/rx_byte. Every newline byte yields one
//   item on out_valid/out_ready with verdict and line_length; all other
//   bytes (CR, NUL and stored bytes) yield nothing; NUL and stored bytes
//   update the line state, and CR leaves it unchanged.
//   cfg_wr_en/cfg_wr_data write max_depth (reset 8); write it only while idle.
//   Result path: a newline accepted into the input register has its result
//   loaded into the result register once that is free, which raises out_valid.
//   Throughput: one byte per cycle while no newline waits on a full result
//   register; the combinational scan logic between the input and result
//   registers updates the line state as each byte is consumed.
//   Stall: while the result register holds an untaken item, non-newline
//   bytes keep flowing; a newline waits in the input register, and
//   in_ready drops until out_ready frees the result register.
//   Reset (rst, synchronous): clears line state, empties both registers
//   and sets max_depth to 8.
module json_line_framer_nesting_guard_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [jlfng_pkg::BYTE_W-1:0]  rx_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [jlfng_pkg::VERD_W-1:0]  verdict,
  output logic [jlfng_pkg::LEN_W-1:0]   line_length,
  input  logic                          cfg_wr_en,
  input  logic [jlfng_pkg::MAXD_W-1:0]  cfg_wr_data
);
  import jlfng_pkg::*;

  logic [MAXD_W-1:0] max_depth;
  logic              held_valid;
  logic [BYTE_W-1:0] held_byte;
  logic              out_free;
  logic              consume;
  line_res_t         res;

  assign out_free = !out_valid || out_ready;
  assign consume  = held_valid && (!res.eol || out_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_depth <= MAXD_RESET;
    end else if (cfg_wr_en) begin
      max_depth <= cfg_wr_data;
    end
  end

  jlfng_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (rx_byte),
    .consume    (consume),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  jlfng_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .max_depth (max_depth),
    .rx        (held_byte),
    .consume   (consume),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= held_valid && res.eol;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && held_valid && res.eol) begin
      verdict     <= res.verdict;
      line_length <= res.length;
    end
  end

endmodule

### bench/json_line_framer_nesting_guard_core_tb.sv
// Testbench for json_line_framer_nesting_guard_core: directed and random byte streams with
// a line-state predictor, ready/valid idling and output backpressure.
// Depends on jlfng_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module json_line_framer_nesting_guard_core_tb;
  import jlfng_pkg::*;

  typedef struct {
    logic [VERD_W-1:0] verdict;
    logic [LEN_W-1:0]  line_len;
  } line_verdict_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [BYTE_W-1:0]  rx_byte;
  logic               out_valid;
  logic               out_ready;
  logic [VERD_W-1:0]  verdict;
  logic [LEN_W-1:0]   line_length;
  logic               cfg_wr_en;
  logic [MAXD_W-1:0]  cfg_wr_data;

  json_line_framer_nesting_guard_core uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .rx_byte     (rx_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .verdict     (verdict),
    .line_length (line_length),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  line_verdict_t      expected_lines[$];
  line_verdict_t      oldest_line;
  int                 errors;
  int                 items_sent;
  bit                 quiet;
  bit                 hold_request;

  logic [MAXD_W-1:0]  depth_limit;
  logic [LEN_W-1:0]   line_count;
  logic               line_ovf;
  logic               line_in_str;
  logic               line_esc;
  logic [DEPTH_W-1:0] line_depth;
  logic [1:0]         line_fault;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #15_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic void clear_line_state();
    line_count  = '0;
    line_ovf    = 1'b0;
    line_in_str = 1'b0;
    line_esc    = 1'b0;
    line_depth  = '0;
    line_fault  = F_NONE;
  endfunction

  function automatic void framer_accept(input logic [BYTE_W-1:0] b);
    line_verdict_t r;
    if (b == CH_LF) begin
      if (line_ovf) r.verdict = V_OVERFLOW;
      else if (line_count == 0) r.verdict = V_EMPTY;
      else if (line_fault == F_TOO_DEEP) r.verdict = V_TOO_DEEP;
      else if (line_fault == F_UNDER) r.verdict = V_UNDERFLOW;
      else if (line_in_str) r.verdict = V_OPEN_STR;
      else if (line_depth != 0) r.verdict = V_UNBALANCED;
      else r.verdict = V_OK;
      r.line_len = line_count;
      expected_lines.push_back(r);
      clear_line_state();
    end else if (b == CH_NUL) begin
      line_ovf = 1'b1;
    end else if (b != CH_CR) begin
      if (!line_ovf && line_count < CNT_LIMIT) begin
        line_count = line_count + 1'b1;
        if (line_fault == F_NONE) begin
          if (line_in_str) begin
            if (line_esc) line_esc = 1'b0;
            else if (b == CH_BSLASH) line_esc = 1'b1;
            else if (b == CH_QUOTE) line_in_str = 1'b0;
          end else if (b == CH_QUOTE) begin
            line_in_str = 1'b1;
          end else if (b == CH_LBRACE || b == CH_LBRACK) begin
            line_depth = line_depth + 1'b1;
            if (line_depth > DEPTH_W'(depth_limit)) line_fault = F_TOO_DEEP;
          end else if (b == CH_RBRACE || b == CH_RBRACK) begin
            if (line_depth == 0) line_fault = F_UNDER;
            else line_depth = line_depth - 1'b1;
          end
        end
      end else begin
        line_ovf = 1'b1;
      end
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_lines.size() == 0) begin
        $error("unexpected item: verdict %0d line_length %0d", verdict, line_length);
        errors++;
      end else begin
        oldest_line = expected_lines.pop_front();
        if (verdict !== oldest_line.verdict) begin
          $error("verdict: expected %0d, got %0d", oldest_line.verdict, verdict);
          errors++;
        end
        if (line_length !== oldest_line.line_len) begin
          $error("line_length: expected %0d, got %0d", oldest_line.line_len, line_length);
          errors++;
        end
      end
    end
  end

  initial begin
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (300) @(negedge clk);
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    framer_accept(b);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_line(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    send_byte(CH_LF);
  endtask

  task automatic send_nest(input int n_open, input int n_close);
    for (int i = 0; i < n_open; i++) send_byte(i[0] ? CH_LBRACE : CH_LBRACK);
    for (int i = 0; i < n_close; i++) send_byte(i[0] ? CH_RBRACE : CH_RBRACK);
    send_byte(CH_LF);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_lines.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_max_depth(input logic [MAXD_W-1:0] d);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= d;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    depth_limit = d;
  endtask

  task automatic send_random_line();
    logic [BYTE_W-1:0] bytes_q[$];
    logic [BYTE_W-1:0] c;
    string filler = "0123456789,:-truefalsn ";
    int open_n;
    int n_tok;
    bit broken;
    open_n = 0;
    broken = ($urandom_range(0, 4) == 0);
    n_tok  = $urandom_range(1, 12);
    repeat (n_tok) begin
      case ($urandom_range(0, broken ? 9 : 8))
        0, 1: begin
          bytes_q.push_back($urandom_range(0, 1) ? CH_LBRACE : CH_LBRACK);
          open_n++;
        end
        2, 3: begin
          if (open_n > 0 || broken) begin
            bytes_q.push_back($urandom_range(0, 1) ? CH_RBRACE : CH_RBRACK);
            if (open_n > 0) open_n--;
          end
        end
        4, 5: begin
          bytes_q.push_back(CH_QUOTE);
          repeat ($urandom_range(0, 6)) begin
            if ($urandom_range(0, 3) == 0) begin
              bytes_q.push_back(CH_BSLASH);
              bytes_q.push_back(BYTE_W'($urandom_range(8'h20, 8'h7e)));
            end else begin
              c = BYTE_W'($urandom_range(8'h20, 8'h7e));
              if (c == CH_QUOTE || c == CH_BSLASH) c = "x";
              bytes_q.push_back(c);
            end
          end
          if (!broken || $urandom_range(0, 1)) bytes_q.push_back(CH_QUOTE);
        end
        9: bytes_q.push_back(BYTE_W'($urandom_range(0, 255)));
        default: bytes_q.push_back(filler[$urandom_range(0, filler.len() - 1)]);
      endcase
    end
    if (!broken || $urandom_range(0, 1)) begin
      repeat (open_n) bytes_q.push_back($urandom_range(0, 1) ? CH_RBRACE : CH_RBRACK);
    end
    if ($urandom_range(0, 3) == 0) bytes_q.push_back(CH_CR);
    bytes_q.push_back(CH_LF);
    foreach (bytes_q[i]) send_byte(bytes_q[i]);
  endtask

  task automatic test_verdicts();
    send_byte(CH_LF);
    send_line("{}");
    send_line("]");
    send_line("\"a\\\"");
    send_line("[]]");
    send_line("\"\\\\\"");
    send_line("{\"k\":[1,2]}");
    send_byte(CH_LBRACK);
    send_byte(CH_LBRACK);
    send_byte(CH_CR);
    send_byte(CH_LF);
    send_byte(CH_CR);
    send_byte(CH_LF);
    send_byte(CH_NUL);
    send_byte(CH_LF);
    send_byte("a");
    send_byte("b");
    send_byte(CH_NUL);
    send_line("cd");
  endtask

  task automatic test_depth_limits();
    set_max_depth(4'd1);
    send_nest(2, 2);
    send_nest(1, 1);
    set_max_depth(4'd15);
    send_nest(15, 15);
    send_nest(16, 16);
    set_max_depth(4'd0);
    send_line("{}");
    send_line("\"{[\"");
    send_line("]\"");
    set_max_depth(MAXD_RESET);
  endtask

  task automatic test_backpressure();
    wait_idle();
    hold_request = 1'b1;
    repeat (10) send_line("{}");
    send_line("[1]");
  endtask

  task automatic test_random();
    logic [MAXD_W-1:0] limits[5];
    int stop;
    limits = '{4'd15, 4'd1, 4'd0, 4'd8, 4'd8};
    limits[3] = MAXD_W'($urandom_range(2, 14));
    for (int p = 0; p < 5; p++) begin
      set_max_depth(limits[p]);
      stop = items_sent + 60;
      while (items_sent < stop) send_random_line();
    end
  endtask

  task automatic test_quiet_tail();
    int stop;
    set_max_depth(MAXD_W'($urandom_range(1, 15)));
    quiet = 1'b1;
    stop = items_sent + 60;
    while (items_sent < stop) send_random_line();
  endtask

  initial begin
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    rx_byte      <= '0;
    out_ready    <= 1'b0;
    cfg_wr_en    <= 1'b0;
    cfg_wr_data  <= '0;
    errors       = 0;
    items_sent   = 0;
    quiet        = 1'b0;
    hold_request = 1'b0;
    depth_limit  = MAXD_RESET;
    clear_line_state();
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    test_verdicts();
    test_depth_limits();
    test_backpressure();
    test_random();
    test_quiet_tail();

    wait_idle();
    repeat (4) @(negedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
